@@ rtl/core/pmt_pkg.sv @@
// shared types and constants for the ps2 mouse packet tracker
// used by pmt_front, pmt_queue, pmt_back and ps2_mouse_packet_tracker
package pmt_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 12;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int SUM_W       = POS_W + 2;
    localparam int LIMIT_W     = POS_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = CFG_W'(400);
    localparam logic [POS_W-1:0] RST_POS_X         = POS_W'(320);
    localparam logic [POS_W-1:0] RST_POS_Y         = POS_W'(200);

    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_X    = 3'b010,
        PH_Y    = 3'b100
    } t_phase;

    typedef struct packed {
        logic [2:0]        buttons;
        logic              x_sign;
        logic              y_sign;
        logic [BYTE_W-1:0] x_byte;
        logic [BYTE_W-1:0] y_byte;
    } t_packet;

    typedef struct packed {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic [2:0]       buttons;
        logic             moved;
        logic             clicked;
        logic [CNT_W-1:0] packet_count;
        logic [CNT_W-1:0] move_count;
        logic [CNT_W-1:0] click_count;
    } t_result;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit_x;
        logic [LIMIT_W-1:0] limit_y;
    } t_limits;

endpackage

@@ rtl/core/pmt_front.sv @@
// byte assembler: tracks packet phase and builds three-byte packets
// depends on pmt_pkg
module pmt_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_from_aux,
    input  logic [pmt_pkg::BYTE_W-1:0] i_data_byte,
    output logic                       o_push,
    output pmt_pkg::t_packet           o_packet
);

    pmt_pkg::t_phase           r_phase, n_phase;
    logic [5:0]                r_header;
    logic [pmt_pkg::BYTE_W-1:0] r_x_byte;

    always_comb begin
        n_phase = r_phase;
        o_push  = 1'b0;
        if (i_accept && i_from_aux) begin
            case (r_phase)
                pmt_pkg::PH_X: n_phase = pmt_pkg::PH_Y;
                pmt_pkg::PH_Y: begin
                    n_phase = pmt_pkg::PH_HEAD;
                    o_push  = 1'b1;
                end
                default: n_phase = i_data_byte[pmt_pkg::HDR_SYNC_BIT] ?
                                   pmt_pkg::PH_X : pmt_pkg::PH_HEAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pmt_pkg::PH_HEAD;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_from_aux) begin
            if (r_phase == pmt_pkg::PH_X) begin
                r_x_byte <= i_data_byte;
            end else if (r_phase != pmt_pkg::PH_Y) begin
                r_header <= i_data_byte[5:0];
            end
        end
    end

    always_comb begin
        o_packet.buttons = r_header[2:0];
        o_packet.x_sign  = r_header[pmt_pkg::HDR_XSIGN_BIT];
        o_packet.y_sign  = r_header[pmt_pkg::HDR_YSIGN_BIT];
        o_packet.x_byte  = r_x_byte;
        o_packet.y_byte  = i_data_byte;
    end

endmodule

@@ rtl/core/pmt_queue.sv @@
// short packet queue between the byte assembler and the tracker
// depends on pmt_pkg
module pmt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pmt_pkg::t_packet i_packet,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output pmt_pkg::t_packet o_packet
);

    pmt_pkg::t_packet r_mem [pmt_pkg::QUEUE_DEPTH];
    logic [pmt_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [pmt_pkg::QCNT_W-1:0] r_count;

    assign o_full     = (r_count == pmt_pkg::QCNT_W'(pmt_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_packet   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == pmt_pkg::QPTR_W'(pmt_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == pmt_pkg::QPTR_W'(pmt_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/pmt_back.sv @@
// tracker: buttons, cursor clamp and counters, with the result register
// depends on pmt_pkg
module pmt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pkt_valid,
    input  pmt_pkg::t_packet i_packet,
    input  pmt_pkg::t_limits i_limits,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_out_valid,
    output pmt_pkg::t_result o_result
);

    logic [pmt_pkg::POS_W-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [2:0]                r_buttons;
    logic [pmt_pkg::CNT_W-1:0] r_packets, r_moves, r_clicks;
    logic [pmt_pkg::CNT_W-1:0] n_packets, n_moves, n_clicks;
    logic                      r_out_valid;
    pmt_pkg::t_result          r_result;

    logic signed [pmt_pkg::SUM_W-1:0] dx, dy, sum_x, sum_y;
    logic                             moved, clicked;

    assign o_pop       = i_pkt_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        dx = pmt_pkg::SUM_W'($signed({i_packet.x_sign, i_packet.x_byte}));
        dy = pmt_pkg::SUM_W'($signed({i_packet.y_sign, i_packet.y_byte}));
        moved   = (dx != '0) || (dy != '0);
        clicked = (i_packet.buttons != r_buttons);
        sum_x = $signed({2'b00, r_pos_x}) + dx;
        sum_y = $signed({2'b00, r_pos_y}) - dy;

        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (moved) begin
            if (sum_x < 0) begin
                n_pos_x = '0;
            end else if (sum_x >= $signed({1'b0, i_limits.limit_x})) begin
                n_pos_x = pmt_pkg::POS_W'(i_limits.limit_x - 1'b1);
            end else begin
                n_pos_x = sum_x[pmt_pkg::POS_W-1:0];
            end
            if (sum_y < 0) begin
                n_pos_y = '0;
            end else if (sum_y >= $signed({1'b0, i_limits.limit_y})) begin
                n_pos_y = pmt_pkg::POS_W'(i_limits.limit_y - 1'b1);
            end else begin
                n_pos_y = sum_y[pmt_pkg::POS_W-1:0];
            end
        end

        n_packets = r_packets + 1'b1;
        n_moves   = moved   ? r_moves + 1'b1  : r_moves;
        n_clicks  = clicked ? r_clicks + 1'b1 : r_clicks;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= pmt_pkg::RST_POS_X;
            r_pos_y     <= pmt_pkg::RST_POS_Y;
            r_buttons   <= '0;
            r_packets   <= '0;
            r_moves     <= '0;
            r_clicks    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos_x   <= n_pos_x;
                r_pos_y   <= n_pos_y;
                r_buttons <= i_packet.buttons;
                r_packets <= n_packets;
                r_moves   <= n_moves;
                r_clicks  <= n_clicks;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result.cursor_x     <= n_pos_x;
            r_result.cursor_y     <= n_pos_y;
            r_result.buttons      <= i_packet.buttons;
            r_result.moved        <= moved;
            r_result.clicked      <= clicked;
            r_result.packet_count <= n_packets;
            r_result.move_count   <= n_moves;
            r_result.click_count  <= n_clicks;
        end
    end

endmodule

@@ rtl/core/ps2_mouse_packet_tracker.sv @@
// top level of the ps2 mouse packet tracker: screen registers and channel glue
// depends on pmt_pkg, pmt_front, pmt_queue, pmt_back
//
//   channel   signals                                     direction
//   in        i_in_valid, o_in_stall, i_from_aux, i_data_byte      byte stream in
//   out       o_out_valid, i_out_stall, o_cursor_x .. o_click_count result out
//   cfg       i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data     register write
//
// one byte per cycle while the input is not stalled; a packet passes through a
// two-entry queue and the result register; the tracker retires one packet per
// cycle unless the output stalls; the input stalls only while the queue is full
// synchronous active-low reset; no clearing pass, the block is ready right after
module ps2_mouse_packet_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_from_aux,
    input  logic [pmt_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pmt_pkg::POS_W-1:0]     o_cursor_x,
    output logic [pmt_pkg::POS_W-1:0]     o_cursor_y,
    output logic                          o_left_button,
    output logic                          o_right_button,
    output logic                          o_middle_button,
    output logic                          o_moved,
    output logic                          o_clicked,
    output logic [pmt_pkg::CNT_W-1:0]     o_packet_count,
    output logic [pmt_pkg::CNT_W-1:0]     o_move_count,
    output logic [pmt_pkg::CNT_W-1:0]     o_click_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pmt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pmt_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [pmt_pkg::CFG_W-1:0] r_screen_width, r_screen_height;
    pmt_pkg::t_limits          limits;
    pmt_pkg::t_packet          front_packet, queue_packet;
    pmt_pkg::t_result          result;
    logic                      in_accept, push, pop, q_full, q_nonempty;

    localparam logic [pmt_pkg::CFG_W-1:0] MAX_LIMIT = pmt_pkg::CFG_W'(1) << pmt_pkg::POS_W;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= pmt_pkg::RST_SCREEN_WIDTH;
            r_screen_height <= pmt_pkg::RST_SCREEN_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pmt_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                pmt_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate screen size to one .. full position range
    always_comb begin
        if (r_screen_width == '0) begin
            limits.limit_x = pmt_pkg::LIMIT_W'(1);
        end else if (r_screen_width > MAX_LIMIT) begin
            limits.limit_x = pmt_pkg::LIMIT_W'(MAX_LIMIT);
        end else begin
            limits.limit_x = pmt_pkg::LIMIT_W'(r_screen_width);
        end
        if (r_screen_height == '0) begin
            limits.limit_y = pmt_pkg::LIMIT_W'(1);
        end else if (r_screen_height > MAX_LIMIT) begin
            limits.limit_y = pmt_pkg::LIMIT_W'(MAX_LIMIT);
        end else begin
            limits.limit_y = pmt_pkg::LIMIT_W'(r_screen_height);
        end
    end

    pmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_from_aux  (i_from_aux),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_packet    (front_packet)
    );

    pmt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_packet   (front_packet),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_packet   (queue_packet)
    );

    pmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_valid (q_nonempty),
        .i_packet    (queue_packet),
        .i_limits    (limits),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_cursor_x      = result.cursor_x;
    assign o_cursor_y      = result.cursor_y;
    assign o_left_button   = result.buttons[0];
    assign o_right_button  = result.buttons[1];
    assign o_middle_button = result.buttons[2];
    assign o_moved         = result.moved;
    assign o_clicked       = result.clicked;
    assign o_packet_count  = result.packet_count;
    assign o_move_count    = result.move_count;
    assign o_click_count   = result.click_count;

endmodule
